@@ sv/ppil_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the priority point-in-polygon lookup
// no dependencies
package ppil_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_REGIONS  = 64;
    localparam int VTX_AW       = $clog2(MAX_VERTICES);
    localparam int RGN_AW       = $clog2(MAX_REGIONS);
    localparam int MIN_LEN      = 3;
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [63:0]        id;
        logic [7:0]         prio;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RADDR,
        S_REVAL,
        S_VWAIT,
        S_VDATA,
        S_VMUL,
        S_VCMP,
        S_OUT
    } state_t;

endpackage

@@ sv/ppil_front.sv @@
`timescale 1ns / 1ps
// front stage: accepts input words, decodes the action and pushes into the queue
// depends on ppil_pkg
module ppil_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic signed [31:0]   coord_x,
    input  logic signed [31:0]   coord_y,
    input  logic [63:0]          close_id,
    input  logic [7:0]           close_priority,
    output logic                 push,
    output ppil_pkg::item_t      push_item,
    input  logic                 q_full
);
    import ppil_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_reg;
    logic  accept;

    assign in_stall  = stage_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = stage_valid_reg && !q_full;
    assign push_item = stage_reg;

    assign stage_valid_next = accept || (stage_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.op   <= op_t'(action);
            stage_reg.x    <= coord_x;
            stage_reg.y    <= coord_y;
            stage_reg.id   <= close_id;
            stage_reg.prio <= close_priority;
        end
    end

endmodule

@@ sv/ppil_queue.sv @@
`timescale 1ns / 1ps
// short word queue between front and back
// depends on ppil_pkg
module ppil_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ppil_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output ppil_pkg::item_t  q_item
);
    import ppil_pkg::*;

    item_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/ppil_back.sv @@
`timescale 1ns / 1ps
// back end: region and vertex stores, query walk and result register
// depends on ppil_pkg
module ppil_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ppil_pkg::item_t  q_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             found,
    output logic [63:0]      hit_id,
    output logic             overflowed
);
    import ppil_pkg::*;

    // stores
    logic [63:0]       vmem     [MAX_VERTICES];
    logic [VTX_AW-1:0] rfirst   [MAX_REGIONS];
    logic [VTX_AW:0]   rlen     [MAX_REGIONS];
    logic [63:0]       rident   [MAX_REGIONS];
    logic [7:0]        rrank    [MAX_REGIONS];

    logic [63:0]       vq_reg;
    logic [VTX_AW-1:0] rq_first_reg;
    logic [VTX_AW:0]   rq_len_reg;
    logic [63:0]       rq_id_reg;
    logic [7:0]        rq_rank_reg;

    // control
    state_t            state_reg, state_next;
    logic [VTX_AW:0]   vcount_reg;
    logic [VTX_AW:0]   open_start_reg;
    logic [RGN_AW:0]   rcount_reg;
    logic              ovf_reg;
    logic              best_valid_reg;
    logic              inside_reg;
    logic              prev_pending_reg;
    logic              out_valid_reg;

    // query datapath
    logic [VTX_AW-1:0]  vaddr_reg;
    logic [RGN_AW-1:0]  raddr_reg;
    logic [VTX_AW:0]    vcnt_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] xj_reg, yj_reg, xi_reg, yi_reg;
    logic signed [32:0] da_reg, dy_reg, dx_reg, dv_reg;
    logic signed [65:0] p1_reg, p2_reg;
    logic               straddle_reg, dypos_reg;
    logic [7:0]         best_rank_reg;
    logic [63:0]        best_id_reg;
    logic               found_reg;
    logic [63:0]        hit_id_reg;
    logic               ovf_out_reg;

    // strobes
    logic              vwe, rwe, load_out, skip, last_region, last_vertex;
    logic              less, inside_final;
    logic [VTX_AW:0]   close_len;
    logic signed [31:0] vq_x, vq_y;

    assign vq_x         = vq_reg[31:0];
    assign vq_y         = vq_reg[63:32];
    assign close_len    = vcount_reg - open_start_reg;
    assign skip         = best_valid_reg && (rq_rank_reg < best_rank_reg);
    assign last_region  = ({1'b0, raddr_reg} + 1'b1) == rcount_reg;
    assign last_vertex  = vcnt_reg == (rq_len_reg - 1'b1);
    assign less         = dypos_reg ? (p1_reg < p2_reg) : (p2_reg < p1_reg);
    assign inside_final = inside_reg ^ (straddle_reg && less);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        vwe        = 1'b0;
        rwe        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    case (q_item.op)
                        OP_APPEND:
                        begin
                            vwe = (vcount_reg < (VTX_AW+1)'(MAX_VERTICES));
                        end
                        OP_CLOSE:
                        begin
                            rwe = (close_len >= (VTX_AW+1)'(MIN_LEN))
                                && (rcount_reg < (RGN_AW+1)'(MAX_REGIONS));
                        end
                        OP_QUERY:
                        begin
                            state_next = (rcount_reg == '0) ? S_OUT : S_RADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RADDR:
            begin
                state_next = S_REVAL;
            end
            S_REVAL:
            begin
                if (skip)
                begin
                    state_next = last_region ? S_OUT : S_RADDR;
                end
                else
                begin
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT:
            begin
                state_next = S_VDATA;
            end
            S_VDATA:
            begin
                state_next = prev_pending_reg ? S_VWAIT : S_VMUL;
            end
            S_VMUL:
            begin
                state_next = S_VCMP;
            end
            S_VCMP:
            begin
                if (last_vertex)
                begin
                    state_next = last_region ? S_OUT : S_RADDR;
                end
                else
                begin
                    state_next = S_VWAIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg       <= '0;
            open_start_reg   <= '0;
            rcount_reg       <= '0;
            ovf_reg          <= 1'b0;
            best_valid_reg   <= 1'b0;
            inside_reg       <= 1'b0;
            prev_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_item.op)
                            OP_CLEAR:
                            begin
                                vcount_reg     <= '0;
                                open_start_reg <= '0;
                                rcount_reg     <= '0;
                                ovf_reg        <= 1'b0;
                            end
                            OP_APPEND:
                            begin
                                if (vwe)
                                begin
                                    vcount_reg <= vcount_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_CLOSE:
                            begin
                                if (rwe)
                                begin
                                    rcount_reg     <= rcount_reg + 1'b1;
                                    open_start_reg <= vcount_reg;
                                end
                                else
                                begin
                                    vcount_reg <= open_start_reg;
                                    if (close_len >= (VTX_AW+1)'(MIN_LEN))
                                    begin
                                        ovf_reg <= 1'b1;
                                    end
                                end
                            end
                            OP_QUERY:
                            begin
                                best_valid_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_REVAL:
                begin
                    inside_reg       <= 1'b0;
                    prev_pending_reg <= 1'b1;
                end
                S_VDATA:
                begin
                    prev_pending_reg <= 1'b0;
                end
                S_VCMP:
                begin
                    inside_reg <= inside_final;
                    if (last_vertex && inside_final)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // query datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                px_reg    <= q_item.x;
                py_reg    <= q_item.y;
                raddr_reg <= '0;
            end
            S_REVAL:
            begin
                if (skip)
                begin
                    raddr_reg <= raddr_reg + 1'b1;
                end
                vaddr_reg <= rq_first_reg + rq_len_reg[VTX_AW-1:0] - 1'b1;
                vcnt_reg  <= '0;
            end
            S_VDATA:
            begin
                if (prev_pending_reg)
                begin
                    xj_reg    <= vq_x;
                    yj_reg    <= vq_y;
                    vaddr_reg <= rq_first_reg;
                end
                else
                begin
                    xi_reg       <= vq_x;
                    yi_reg       <= vq_y;
                    straddle_reg <= (vq_y > py_reg) != (yj_reg > py_reg);
                    da_reg       <= 33'(px_reg) - 33'(vq_x);
                    dy_reg       <= 33'(yj_reg) - 33'(vq_y);
                    dx_reg       <= 33'(xj_reg) - 33'(vq_x);
                    dv_reg       <= 33'(py_reg) - 33'(vq_y);
                end
            end
            S_VMUL:
            begin
                p1_reg    <= da_reg * dy_reg;
                p2_reg    <= dx_reg * dv_reg;
                dypos_reg <= dy_reg > 33'sd0;
            end
            S_VCMP:
            begin
                xj_reg    <= xi_reg;
                yj_reg    <= yi_reg;
                vcnt_reg  <= vcnt_reg + 1'b1;
                vaddr_reg <= vaddr_reg + 1'b1;
                if (last_vertex)
                begin
                    raddr_reg <= raddr_reg + 1'b1;
                    if (inside_final)
                    begin
                        best_rank_reg <= rq_rank_reg;
                        best_id_reg   <= rq_id_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            found_reg   <= best_valid_reg;
            hit_id_reg  <= best_valid_reg ? best_id_reg : 64'd0;
            ovf_out_reg <= ovf_reg;
        end
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vcount_reg[VTX_AW-1:0]] <= {q_item.y, q_item.x};
        end
        vq_reg <= vmem[vaddr_reg];
    end

    // region tables
    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rfirst[rcount_reg[RGN_AW-1:0]] <= open_start_reg[VTX_AW-1:0];
            rlen[rcount_reg[RGN_AW-1:0]]   <= close_len;
            rident[rcount_reg[RGN_AW-1:0]] <= q_item.id;
            rrank[rcount_reg[RGN_AW-1:0]]  <= q_item.prio;
        end
        rq_first_reg <= rfirst[raddr_reg];
        rq_len_reg   <= rlen[raddr_reg];
        rq_id_reg    <= rident[raddr_reg];
        rq_rank_reg  <= rrank[raddr_reg];
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign hit_id     = hit_id_reg;
    assign overflowed = ovf_out_reg;

    a_region_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= (RGN_AW+1)'(MAX_REGIONS))
        else $error("region count beyond capacity");

    a_open_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_start_reg <= vcount_reg)
        else $error("open region start past vertex count");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped during a query walk");

    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("result not presented after query");

endmodule

@@ sv/priority_point_in_polygon_lookup.sv @@
`timescale 1ns / 1ps
// top level of the priority point-in-polygon lookup
// depends on ppil_pkg, ppil_front, ppil_queue, ppil_back
//
//   channel | handshake           | fields
//   input   | in_valid / in_stall | action, coord_x, coord_y, close_id, close_priority
//   output  | out_valid/out_stall | found, hit_id, overflowed
//
// clear, append and close are handled in the back end's idle state as they are popped
// a query walks the regions and their vertices in the back end, paced by the
// registered read of the vertex store and the edge multiplier
// regions ranked below the current best skip the vertex walk and cost only their table read
// reset empties all stores and clears the overflow flag
// the queue keeps taking words, until it is full, while a result waits on out_stall
module priority_point_in_polygon_lookup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic [63:0]         close_id,
    input  logic [7:0]          close_priority,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [63:0]         hit_id,
    output logic                overflowed
);
    import ppil_pkg::*;

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  pop;
    logic  q_valid;
    item_t q_item;

    ppil_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .close_id       (close_id),
        .close_priority (close_priority),
        .push           (push),
        .push_item      (push_item),
        .q_full         (q_full)
    );

    ppil_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ppil_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .hit_id     (hit_id),
        .overflowed (overflowed)
    );

endmodule
